// ----- hdl/kmc_pkg.sv -----
// package: shared types and codes for the k-means clustering engine
`timescale 1ns / 1ps
`default_nettype none
package kmc_pkg;

  // item function codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ASSIGN = 2'd1;
  localparam logic [1:0] FUNC_CENTER = 2'd2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_DIMS     = 2'd1;
  localparam logic [1:0] REG_MAX_ITER = 2'd2;

  // register reset values
  localparam logic [4:0] RST_CLUSTERS = 5'd2;
  localparam logic [8:0] RST_DIMS     = 9'd1;
  localparam logic [7:0] RST_MAX_ITER = 8'd100;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_RECALC,
    S_RECALC_W,
    S_HRD,
    S_EMIT,
    S_RR_CLR,
    S_RR,
    S_CHECK,
    S_SCLR,
    S_APT,
    S_ACAP,
    S_ERD,
    S_EWR,
    S_DRD,
    S_DGO,
    S_DW,
    S_RCLR,
    S_PAS,
    S_PCAP,
    S_XRD,
    S_XMUL,
    S_XW1,
    S_XCMP,
    S_XUPD
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/kmc_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module kmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/kmc_div.sv -----
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module kmc_div #(
  parameter int NW = 27,
  parameter int VW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient,
  output logic [VW-1:0]      remainder
);

  localparam int CNTW = $clog2(NW + 1);

  logic [VW-1:0]   rem;
  logic [NW-1:0]   quo;
  logic [VW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic            run;
  logic [VW:0]     trial;
  logic            fits;

  // one shift-subtract step
  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(NW);
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (run) begin
        rem <= fits ? VW'(trial - {1'b0, dvs}) : VW'(trial);
        quo <= {quo[NW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

// ----- hdl/kmc_dist.sv -----
// squared-distance accumulator: abs difference, registered square, running sum
`timescale 1ns / 1ps
`default_nettype none
module kmc_dist #(
  parameter int AW = 41
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clr,
  input  wire logic          en,
  input  wire logic [15:0]   f,
  input  wire logic [15:0]   m,
  output logic      [AW-1:0] acc
);

  logic [15:0] ad;
  logic [31:0] sq;
  logic        sq_vld;

  assign ad = (f > m) ? (f - m) : (m - f);

  // square stage then accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
      acc    <= '0;
    end else begin
      sq_vld <= en;
      if (clr) begin
        acc <= '0;
      end else if (sq_vld) begin
        acc <= acc + AW'(sq);
      end
    end
    sq <= 32'(ad) * 32'(ad);
  end

endmodule
`default_nettype wire

// ----- hdl/kmeans_clustering_engine.sv -----
// top level: k-means clustering engine with sequencer and shared units
//
// Usage: items enter on start while busy is low. func 0 appends one feature
// element (row-major, point after point); func 1 reads a point's cluster;
// func 2 reads a center element and its cluster's member count. Each item
// gives exactly one result, shown for one cycle with done high; the receiver
// cannot stall it.
// A plain load passes through S_EMIT before done rises, a read through S_HRD
// and then S_EMIT; the next item can be taken at the edge that ends the done
// cycle, so items never overlap.
// A load with last_element runs clustering first: a round-robin start, then
// per pass K*D sum clears, N*D sum updates, K*D means through the shared
// divider, and N*K*D distance terms through the shared square and accumulate
// unit, for N points, K clusters and D elements per point.
// Writing num_dims while idle recomputes the held point count with the divider;
// busy stays high meanwhile. The configuration port is APB-style.
// Reset clears counters and status; the data stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module kmeans_clustering_engine #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_DIMS     = 256,
  parameter int MAX_CLUSTERS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [15:0] feature,
  input  wire logic        last_element,
  input  wire logic [9:0]  point_index,
  input  wire logic [3:0]  cluster_index,
  input  wire logic [7:0]  dim_index,
  output logic             done,
  output logic [15:0]      read_value,
  output logic [10:0]      cluster_count,
  output logic [7:0]       passes_run,
  output logic             converged,
  output logic [10:0]      last_changes,
  output logic [10:0]      point_count,
  output logic             overflow
);

  localparam int AW   = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int EW   = $clog2(MAX_POINTS * MAX_DIMS + 1);
  localparam int PC   = $clog2(MAX_POINTS + 1);
  localparam int PI   = $clog2(MAX_POINTS);
  localparam int KW   = $clog2(MAX_CLUSTERS);
  localparam int KC   = $clog2(MAX_CLUSTERS + 1);
  localparam int DI   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DCW  = $clog2(MAX_DIMS + 1);
  localparam int SW   = 16 + PC;
  localparam int NW   = (SW > EW) ? SW : EW;
  localparam int VW   = (PC > DCW) ? PC : DCW;
  localparam int XW   = 32 + DCW;
  localparam int CDEP = MAX_CLUSTERS * (2 ** DI);

  kmc_pkg::state_t state, state_next;

  // configuration registers
  logic [4:0] num_clusters;
  logic [8:0] num_dims;
  logic [7:0] max_iter;
  logic       cfg_wr;

  // counters and sequencer registers
  logic [EW-1:0]  ec, pts, pbase;
  logic [DCW-1:0] rem;
  logic [PC-1:0]  i, chg;
  logic [KC-1:0]  c;
  logic [DCW-1:0] d;
  logic [KW-1:0]  rr, cur, best, old;
  logic [XW-1:0]  bestd;
  logic [7:0]     pass;
  logic           conv;
  logic [PC-1:0]  cnt [MAX_CLUSTERS];

  // latched request
  logic [1:0]    h_func;
  logic          h_okp, h_okc, h_okd;
  logic [KW-1:0] h_cidx;
  logic [15:0]   rv;
  logic [PC-1:0] hc;
  logic          ovf;

  // derived values
  logic [DCW-1:0] nd;
  logic [KC-1:0]  k;
  logic [PC-1:0]  np;
  logic           d_last, c_last, i_last, accept;
  logic [KW-1:0]  cnt_sel;
  logic [PC-1:0]  cnt_rd;

  // ram ports
  logic              f_we;
  logic [AW-1:0]     f_raddr;
  logic [15:0]       f_rd;
  logic              a_we;
  logic [PI-1:0]     a_raddr;
  logic [KW-1:0]     a_wdata, a_rd;
  logic              s_we;
  logic [KW+DI-1:0]  s_addr;
  logic [SW-1:0]     s_wdata, s_rd;
  logic              c_we;
  logic [KW+DI-1:0]  c_waddr, c_raddr;
  logic [15:0]       c_wdata, c_rd;

  // shared units
  logic          div_start, div_done;
  logic [NW-1:0] div_n, div_q;
  logic [VW-1:0] div_v, div_r;
  logic          dist_clr, dist_en;
  logic [XW-1:0] dist_acc;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign busy   = state != kmc_pkg::S_IDLE;
  assign accept = start & ~busy;

  // effective configuration
  always_comb begin
    if (num_dims == 9'd0) begin
      nd = DCW'(1);
    end else if (32'(num_dims) > MAX_DIMS) begin
      nd = DCW'(MAX_DIMS);
    end else begin
      nd = DCW'(num_dims);
    end
    if (num_clusters == 5'd0) begin
      k = KC'(1);
    end else if (32'(num_clusters) > MAX_CLUSTERS) begin
      k = KC'(MAX_CLUSTERS);
    end else begin
      k = KC'(num_clusters);
    end
    np = (32'(pts) > MAX_POINTS) ? PC'(MAX_POINTS) : PC'(pts);
  end

  assign d_last = d == nd - DCW'(1);
  assign c_last = c == k - KC'(1);
  assign i_last = i == np - PC'(1);
  assign cnt_rd = cnt[cnt_sel];

  // register read-back
  always_comb begin
    unique case (paddr[3:2])
      kmc_pkg::REG_CLUSTERS: prdata = 32'(num_clusters);
      kmc_pkg::REG_DIMS:     prdata = 32'(num_dims);
      kmc_pkg::REG_MAX_ITER: prdata = 32'(max_iter);
      default:               prdata = '0;
    endcase
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= kmc_pkg::RST_CLUSTERS;
      num_dims     <= kmc_pkg::RST_DIMS;
      max_iter     <= kmc_pkg::RST_MAX_ITER;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        kmc_pkg::REG_CLUSTERS: num_clusters <= pwdata[4:0];
        kmc_pkg::REG_DIMS:     num_dims     <= pwdata[8:0];
        kmc_pkg::REG_MAX_ITER: max_iter     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kmc_pkg::S_IDLE: begin
        if (cfg_wr && paddr[3:2] == kmc_pkg::REG_DIMS) begin
          state_next = kmc_pkg::S_RECALC;
        end else if (accept) begin
          if (func == kmc_pkg::FUNC_LOAD) begin
            state_next = last_element ? kmc_pkg::S_RR_CLR : kmc_pkg::S_EMIT;
          end else begin
            state_next = kmc_pkg::S_HRD;
          end
        end
      end
      kmc_pkg::S_RECALC:   state_next = kmc_pkg::S_RECALC_W;
      kmc_pkg::S_RECALC_W: if (div_done) state_next = kmc_pkg::S_IDLE;
      kmc_pkg::S_HRD:      state_next = kmc_pkg::S_EMIT;
      kmc_pkg::S_EMIT:     state_next = kmc_pkg::S_IDLE;
      kmc_pkg::S_RR_CLR:   state_next = kmc_pkg::S_RR;
      kmc_pkg::S_RR:       if (i == np) state_next = kmc_pkg::S_CHECK;
      kmc_pkg::S_CHECK: begin
        if (chg != '0 && pass < max_iter) begin
          state_next = kmc_pkg::S_SCLR;
        end else begin
          state_next = kmc_pkg::S_EMIT;
        end
      end
      kmc_pkg::S_SCLR:     if (d_last && c_last) state_next = kmc_pkg::S_APT;
      kmc_pkg::S_APT:      state_next = kmc_pkg::S_ACAP;
      kmc_pkg::S_ACAP:     state_next = kmc_pkg::S_ERD;
      kmc_pkg::S_ERD:      state_next = kmc_pkg::S_EWR;
      kmc_pkg::S_EWR: begin
        if (!d_last) begin
          state_next = kmc_pkg::S_ERD;
        end else begin
          state_next = i_last ? kmc_pkg::S_DRD : kmc_pkg::S_APT;
        end
      end
      kmc_pkg::S_DRD:      state_next = kmc_pkg::S_DGO;
      kmc_pkg::S_DGO: begin
        if (cnt_rd != '0) begin
          state_next = kmc_pkg::S_DW;
        end else begin
          state_next = (d_last && c_last) ? kmc_pkg::S_RCLR : kmc_pkg::S_DRD;
        end
      end
      kmc_pkg::S_DW: begin
        if (div_done) begin
          state_next = (d_last && c_last) ? kmc_pkg::S_RCLR : kmc_pkg::S_DRD;
        end
      end
      kmc_pkg::S_RCLR:     state_next = kmc_pkg::S_PAS;
      kmc_pkg::S_PAS:      state_next = kmc_pkg::S_PCAP;
      kmc_pkg::S_PCAP:     state_next = kmc_pkg::S_XRD;
      kmc_pkg::S_XRD:      state_next = kmc_pkg::S_XMUL;
      kmc_pkg::S_XMUL:     state_next = d_last ? kmc_pkg::S_XW1 : kmc_pkg::S_XRD;
      kmc_pkg::S_XW1:      state_next = kmc_pkg::S_XCMP;
      kmc_pkg::S_XCMP:     state_next = c_last ? kmc_pkg::S_XUPD : kmc_pkg::S_XRD;
      kmc_pkg::S_XUPD:     state_next = i_last ? kmc_pkg::S_CHECK : kmc_pkg::S_PAS;
      default:             state_next = kmc_pkg::S_IDLE;
    endcase
  end

  // control outputs to rams and shared units
  always_comb begin
    f_we      = 1'b0;
    f_raddr   = AW'(pbase + EW'(d));
    a_we      = 1'b0;
    a_raddr   = PI'(i);
    a_wdata   = rr;
    s_we      = 1'b0;
    s_addr    = {c[KW-1:0], DI'(d)};
    s_wdata   = '0;
    c_we      = 1'b0;
    c_waddr   = {c[KW-1:0], DI'(d)};
    c_wdata   = '0;
    c_raddr   = {c[KW-1:0], DI'(d)};
    cnt_sel   = h_cidx;
    div_start = 1'b0;
    div_n     = NW'(s_rd);
    div_v     = VW'(cnt_rd);
    dist_clr  = 1'b0;
    dist_en   = 1'b0;
    unique case (state)
      kmc_pkg::S_IDLE: begin
        f_we    = accept && func == kmc_pkg::FUNC_LOAD && 32'(pts) < MAX_POINTS;
        a_raddr = PI'(point_index);
        c_raddr = {KW'(cluster_index), DI'(dim_index)};
      end
      kmc_pkg::S_RECALC: begin
        div_start = 1'b1;
        div_n     = NW'(ec);
        div_v     = VW'(nd);
      end
      kmc_pkg::S_RR: begin
        cnt_sel = rr;
        a_we    = i != np;
      end
      kmc_pkg::S_SCLR: s_we = 1'b1;
      kmc_pkg::S_ERD:  s_addr = {cur, DI'(d)};
      kmc_pkg::S_EWR: begin
        s_addr  = {cur, DI'(d)};
        s_we    = 1'b1;
        s_wdata = s_rd + SW'(f_rd);
      end
      kmc_pkg::S_DGO: begin
        cnt_sel   = c[KW-1:0];
        c_we      = cnt_rd == '0;
        div_start = cnt_rd != '0;
      end
      kmc_pkg::S_DW: begin
        c_we    = div_done;
        c_wdata = 16'(div_q);
      end
      kmc_pkg::S_XRD:  dist_clr = d == '0;
      kmc_pkg::S_XMUL: dist_en = 1'b1;
      kmc_pkg::S_XUPD: begin
        cnt_sel = best;
        a_we    = old != best;
        a_wdata = best;
      end
      default: ;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmc_pkg::S_IDLE;
      ec    <= '0;
      pts   <= '0;
      rem   <= '0;
      pass  <= '0;
      chg   <= '0;
      conv  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        kmc_pkg::S_IDLE: begin
          if (accept && !(cfg_wr && paddr[3:2] == kmc_pkg::REG_DIMS)) begin
            h_func <= func;
            h_okp  <= 32'(point_index) < MAX_POINTS;
            h_okc  <= 32'(cluster_index) < MAX_CLUSTERS;
            h_okd  <= 32'(dim_index) < MAX_DIMS;
            h_cidx <= KW'(cluster_index);
            rv     <= '0;
            hc     <= '0;
            ovf    <= 1'b0;
            if (func == kmc_pkg::FUNC_LOAD) begin
              if (32'(pts) < MAX_POINTS) begin
                ec <= ec + EW'(1);
                if (rem + DCW'(1) == nd) begin
                  rem <= '0;
                  pts <= pts + EW'(1);
                end else begin
                  rem <= rem + DCW'(1);
                end
              end else begin
                ovf <= 1'b1;
              end
              if (last_element) begin
                for (int j = 0; j < MAX_CLUSTERS; j++) begin
                  if (j < int'(k)) cnt[j] <= '0;
                end
              end
            end
          end
        end
        kmc_pkg::S_RECALC_W: begin
          if (div_done) begin
            pts <= EW'(div_q);
            rem <= DCW'(div_r);
          end
        end
        kmc_pkg::S_HRD: begin
          if (h_func == kmc_pkg::FUNC_ASSIGN && h_okp) begin
            rv <= 16'(a_rd);
          end else if (h_func == kmc_pkg::FUNC_CENTER && h_okc && h_okd) begin
            rv <= c_rd;
          end
          if (h_func == kmc_pkg::FUNC_CENTER && h_okc) hc <= cnt_rd;
        end
        kmc_pkg::S_EMIT: begin
          done          <= 1'b1;
          read_value    <= rv;
          cluster_count <= 11'(hc);
          passes_run    <= pass;
          converged     <= conv;
          last_changes  <= 11'(chg);
          point_count   <= 11'(np);
          overflow      <= ovf;
        end
        kmc_pkg::S_RR_CLR: begin
          i  <= '0;
          rr <= '0;
        end
        kmc_pkg::S_RR: begin
          if (i != np) begin
            cnt[rr] <= cnt_rd + PC'(1);
            i       <= i + PC'(1);
            rr      <= (KC'(rr) == k - KC'(1)) ? '0 : rr + KW'(1);
          end else begin
            chg  <= np;
            pass <= '0;
          end
        end
        kmc_pkg::S_CHECK: begin
          c     <= '0;
          d     <= '0;
          i     <= '0;
          pbase <= '0;
          conv  <= chg == '0;
        end
        kmc_pkg::S_SCLR: begin
          if (d_last) begin
            d <= '0;
            c <= c_last ? '0 : c + KC'(1);
          end else begin
            d <= d + DCW'(1);
          end
        end
        kmc_pkg::S_ACAP: begin
          cur <= a_rd;
          d   <= '0;
        end
        kmc_pkg::S_EWR: begin
          if (d_last) begin
            d     <= '0;
            i     <= i + PC'(1);
            pbase <= pbase + EW'(nd);
          end else begin
            d <= d + DCW'(1);
          end
        end
        kmc_pkg::S_DGO, kmc_pkg::S_DW: begin
          if ((state == kmc_pkg::S_DGO && cnt_rd == '0) ||
              (state == kmc_pkg::S_DW && div_done)) begin
            if (d_last) begin
              d <= '0;
              c <= c + KC'(1);
            end else begin
              d <= d + DCW'(1);
            end
          end
        end
        kmc_pkg::S_RCLR: begin
          for (int j = 0; j < MAX_CLUSTERS; j++) begin
            if (j < int'(k)) cnt[j] <= '0;
          end
          chg   <= '0;
          i     <= '0;
          pbase <= '0;
        end
        kmc_pkg::S_PCAP: begin
          old <= a_rd;
          c   <= '0;
          d   <= '0;
        end
        kmc_pkg::S_XMUL: begin
          d <= d_last ? '0 : d + DCW'(1);
        end
        kmc_pkg::S_XCMP: begin
          if (c == '0 || dist_acc < bestd) begin
            best  <= c[KW-1:0];
            bestd <= dist_acc;
          end
          c <= c + KC'(1);
        end
        kmc_pkg::S_XUPD: begin
          cnt[best] <= cnt_rd + PC'(1);
          if (old != best) chg <= chg + PC'(1);
          i     <= i + PC'(1);
          pbase <= pbase + EW'(nd);
          if (i_last) pass <= pass + 8'd1;
        end
        default: ;
      endcase
    end
  end

  // data stores
  kmc_ram #(.WIDTH(16), .DEPTH(MAX_POINTS * MAX_DIMS)) u_feat (
    .clk(clk), .we(f_we), .waddr(AW'(ec)), .wdata(feature),
    .raddr(f_raddr), .rdata(f_rd)
  );

  kmc_ram #(.WIDTH(KW), .DEPTH(MAX_POINTS)) u_asg (
    .clk(clk), .we(a_we), .waddr(PI'(i)), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rd)
  );

  kmc_ram #(.WIDTH(SW), .DEPTH(CDEP)) u_sum (
    .clk(clk), .we(s_we), .waddr(s_addr), .wdata(s_wdata),
    .raddr(s_addr), .rdata(s_rd)
  );

  kmc_ram #(.WIDTH(16), .DEPTH(CDEP)) u_cent (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rd)
  );

  // shared divider for center means and point count
  kmc_div #(.NW(NW), .VW(VW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_v),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  // shared squared-distance unit
  kmc_dist #(.AW(XW)) u_dist (
    .clk(clk), .rst(rst), .clr(dist_clr), .en(dist_en),
    .f(f_rd), .m(c_rd), .acc(dist_acc)
  );

endmodule
`default_nettype wire
